// File: hdl/assert_macros.svh
// assertion macros used by the checker file bapc_checker.sv
// needs a clock and an active-high reset passed in by the caller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("port check failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("port check failed");

`endif

// File: hdl/bapc_pkg.sv
// shared types, constants and the divider step for the block average converter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bapc_pkg;

   localparam int MAX_SAMPLES = 1024;

   // field widths
   localparam int TIME_W = 32;
   localparam int TEMP_W = 16;
   localparam int PRES_W = 12;
   localparam int MT_W   = 31;
   localparam int TD_W   = 20;
   localparam int PM_W   = 23;

   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 80;

   // configuration
   localparam int SCNT_W     = 11;
   localparam int REF_W      = 13;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 13;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_COUNT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REF_VOLTAGE  = 1'd1;
   localparam logic [SCNT_W-1:0]    SAMPLE_COUNT_RST = 11'd10;
   localparam logic [REF_W-1:0]     REF_VOLTAGE_RST  = 13'd3300;

   // running sums
   localparam int TSUM_W = 42;
   localparam int MSUM_W = 26;
   localparam int PSUM_W = 22;
   localparam int PNUM_W = REF_W + PSUM_W;

   // shared divider: 51-bit dividend, 22-bit divisor, 32 quotient bits, two per cycle
   localparam int NUM_W     = 51;
   localparam int DEN_W     = 22;
   localparam int QUO_W     = 32;
   localparam int DIV_STEPS = QUO_W / 2;
   localparam int DCNT_W    = $clog2(DIV_STEPS);

   localparam int TIME_DIV = 1000;
   localparam int ADC_FULL = 4095;

   // pressure conversion
   localparam int V_W    = 29;
   localparam int GAIN_W = 26;
   localparam int PROD_W = (V_W + 1) + (GAIN_W + 1);
   localparam logic [GAIN_W-1:0] PRES_GAIN_Q16 = 26'd42364873;
   localparam logic [V_W:0]      OFFSET_Q16    = 30'd65536000;
   localparam int PRES_MAX = 4194303;
   localparam int PRES_MIN = -4194304;

   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic        [TSUM_W-1:0] time_sum;
      logic signed [MSUM_W-1:0] temp_sum;
      logic        [PSUM_W-1:0] pres_sum;
      logic        [SCNT_W-1:0] n;
      logic        [REF_W-1:0]  ref_mv;
   } job_type;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] dividend;
      logic [DEN_W-1:0] divisor;
   } div_ctl_type;

   typedef struct packed {
      logic             done;
      logic [QUO_W-1:0] quotient;
   } div_sts_type;

   // one restoring step: returns {quotient bit, new remainder}
   function automatic logic [DEN_W:0] div_step(input logic [DEN_W-1:0] rem,
                                               input logic             din,
                                               input logic [DEN_W-1:0] den);
      logic [DEN_W:0] trial;
      logic [DEN_W:0] diff;
      trial = {rem, din};
      diff  = trial - {1'b0, den};
      if (trial >= {1'b0, den}) begin
         div_step = {1'b1, diff[DEN_W-1:0]};
      end else begin
         div_step = {1'b0, trial[DEN_W-1:0]};
      end
   endfunction

endpackage

`default_nettype wire

// File: hdl/block_average_pt_converter_unit.sv
// Block-average converter for pressure/temperature sensor records. Records are
// taken at up to one per cycle and summed; when a window of sample_count records
// is complete (0 counts as 1, values above 1024 as 1024) the sums enter a two-entry
// job queue and the back end turns them into one result: mean time / 1000 in Q8,
// mean temperature in degrees Q8, and pressure in milliTorr. Each window takes
// the back end through three divisions (16 two-bit steps each) on one shared
// divider; a result held by rsp_tready stalls it. The front end keeps taking
// records while the back end converts earlier windows; req_tready drops only
// while the job queue is full.
// Top level: configuration registers and the front, queue, divider and back end.
// Depends on bapc_pkg, bapc_front, bapc_queue, bapc_div, bapc_back.
`timescale 1ns / 1ps
`default_nettype none

module block_average_pt_converter_unit import bapc_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // time_stamp[31:0], temp_code[47:32], pres_code[59:48], zero pad
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // mean_time_q8[30:0], temp_degrees_q8[50:31], pressure_mtorr[73:51], zero pad
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   logic [SCNT_W-1:0] sample_count_ff;
   logic [REF_W-1:0]  ref_voltage_ff;

   logic        q_push;
   logic        q_pop;
   logic        q_full;
   logic        q_empty;
   job_type     push_job;
   job_type     pop_job;
   div_ctl_type div_ctl;
   div_sts_type div_sts;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_count_ff <= SAMPLE_COUNT_RST;
         ref_voltage_ff  <= REF_VOLTAGE_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_SAMPLE_COUNT: sample_count_ff <= csr_data[SCNT_W-1:0];
            CSR_REF_VOLTAGE:  ref_voltage_ff  <= csr_data[REF_W-1:0];
            default: ;
         endcase
      end
   end

   bapc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .sample_count (sample_count_ff),
      .ref_mv       (ref_voltage_ff),
      .q_full       (q_full),
      .push         (q_push),
      .push_job     (push_job)
   );

   bapc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .pop_job  (pop_job),
      .full     (q_full),
      .empty    (q_empty)
   );

   bapc_div u_div (
      .clock (clock),
      .reset (reset),
      .ctl   (div_ctl),
      .sts   (div_sts)
   );

   bapc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_job      (pop_job),
      .q_pop      (q_pop),
      .div_ctl    (div_ctl),
      .div_sts    (div_sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

// File: hdl/bapc_div.sv
// shared radix-4 restoring divider, two quotient bits per cycle
// depends on bapc_pkg
`timescale 1ns / 1ps
`default_nettype none

module bapc_div import bapc_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_ctl_type ctl,
   output div_sts_type      sts
);

   logic              busy_ff;
   logic              done_ff;
   logic [DCNT_W-1:0] cnt_ff;
   logic [DEN_W-1:0]  rem_ff;
   logic [DEN_W-1:0]  den_ff;
   logic [QUO_W-1:0]  shf_ff;
   logic [DEN_W:0]    s1;
   logic [DEN_W:0]    s2;

   assign s1 = div_step(rem_ff, shf_ff[QUO_W-1], den_ff);
   assign s2 = div_step(s1[DEN_W-1:0], shf_ff[QUO_W-2], den_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (ctl.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == DCNT_W'(DIV_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // top dividend bits are known to sit below the divisor, so they seed the remainder
   always_ff @(posedge clock) begin
      if (ctl.start) begin
         rem_ff <= {{(DEN_W - (NUM_W - QUO_W)){1'b0}}, ctl.dividend[NUM_W-1:QUO_W]};
         den_ff <= ctl.divisor;
         shf_ff <= ctl.dividend[QUO_W-1:0];
      end else if (busy_ff) begin
         rem_ff <= s2[DEN_W-1:0];
         shf_ff <= {shf_ff[QUO_W-3:0], s1[DEN_W], s2[DEN_W]};
      end
   end

   assign sts.done     = done_ff;
   assign sts.quotient = shf_ff;

endmodule

`default_nettype wire

// File: hdl/bapc_queue.sv
// short job queue between the accumulator and the conversion back end
// depends on bapc_pkg
`timescale 1ns / 1ps
`default_nettype none

module bapc_queue import bapc_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   input  wire logic    pop,
   output job_type      pop_job,
   output logic         full,
   output logic         empty
);

   localparam int Q_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int Q_CNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type              entry_ff [QUEUE_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff;
   logic [Q_PTR_W-1:0]   rd_ptr_ff;
   logic [Q_CNT_W-1:0]   fill_ff;
   logic                 do_push;
   logic                 do_pop;

   assign full    = (fill_ff == Q_CNT_W'(QUEUE_DEPTH));
   assign empty   = (fill_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign pop_job = entry_ff[rd_ptr_ff];

   function automatic logic [Q_PTR_W-1:0] ptr_next(input logic [Q_PTR_W-1:0] p);
      if (p == Q_PTR_W'(QUEUE_DEPTH - 1)) begin
         ptr_next = '0;
      end else begin
         ptr_next = p + 1'b1;
      end
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= ptr_next(wr_ptr_ff);
         if (do_pop)  rd_ptr_ff <= ptr_next(rd_ptr_ff);
         if (do_push && !do_pop) begin
            fill_ff <= fill_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            fill_ff <= fill_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_job;
   end

endmodule

`default_nettype wire

// File: hdl/bapc_front.sv
// record accumulator: keeps the three running sums and the record count,
// hands a finished window to the job queue; depends on bapc_pkg
`timescale 1ns / 1ps
`default_nettype none

module bapc_front import bapc_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire logic [REQ_DATA_W-1:0]   req_tdata,
   input  wire logic [SCNT_W-1:0]       sample_count,
   input  wire logic [REF_W-1:0]        ref_mv,
   input  wire logic                    q_full,
   output logic                         push,
   output job_type                      push_job
);

   logic        [TSUM_W-1:0] time_sum_ff;
   logic signed [MSUM_W-1:0] temp_sum_ff;
   logic        [PSUM_W-1:0] pres_sum_ff;
   logic        [SCNT_W-1:0] count_ff;

   logic        [TSUM_W-1:0] time_sum_in;
   logic signed [MSUM_W-1:0] temp_sum_in;
   logic        [PSUM_W-1:0] pres_sum_in;
   logic        [SCNT_W-1:0] count_in;

   logic        [TIME_W-1:0] ts;
   logic signed [TEMP_W-1:0] tc;
   logic        [PRES_W-1:0] pc;
   logic        [SCNT_W-1:0] win_len;
   logic                     accept;
   logic                     window_end;

   assign ts = req_tdata[TIME_W-1:0];
   assign tc = req_tdata[TIME_W+TEMP_W-1:TIME_W];
   assign pc = req_tdata[TIME_W+TEMP_W+PRES_W-1:TIME_W+TEMP_W];

   // zero acts as one, anything past the maximum is clamped
   always_comb begin
      win_len = sample_count;
      if (sample_count == '0) win_len = SCNT_W'(1);
      if (sample_count > SCNT_W'(MAX_SAMPLES)) win_len = SCNT_W'(MAX_SAMPLES);
   end

   assign req_tready = ~q_full;
   assign accept     = req_tvalid & ~q_full;

   assign time_sum_in = time_sum_ff + {{(TSUM_W - TIME_W){1'b0}}, ts};
   assign temp_sum_in = temp_sum_ff + {{(MSUM_W - TEMP_W){tc[TEMP_W-1]}}, tc};
   assign pres_sum_in = pres_sum_ff + {{(PSUM_W - PRES_W){1'b0}}, pc};
   assign count_in    = count_ff + 1'b1;

   // >= so a length lowered mid-window closes on the next record
   assign window_end = (count_in >= win_len);

   assign push              = accept & window_end;
   assign push_job.time_sum = time_sum_in;
   assign push_job.temp_sum = temp_sum_in;
   assign push_job.pres_sum = pres_sum_in;
   assign push_job.n        = count_in;
   assign push_job.ref_mv   = ref_mv;

   always_ff @(posedge clock) begin
      if (reset) begin
         time_sum_ff <= '0;
         temp_sum_ff <= '0;
         pres_sum_ff <= '0;
         count_ff    <= '0;
      end else if (accept) begin
         if (window_end) begin
            time_sum_ff <= '0;
            temp_sum_ff <= '0;
            pres_sum_ff <= '0;
            count_ff    <= '0;
         end else begin
            time_sum_ff <= time_sum_in;
            temp_sum_ff <= temp_sum_in;
            pres_sum_ff <= pres_sum_in;
            count_ff    <= count_in;
         end
      end
   end

endmodule

`default_nettype wire

// File: hdl/bapc_back.sv
// conversion back end: pops a window, runs the three divisions on the shared
// divider, applies the pressure gain and holds the result; depends on bapc_pkg
`timescale 1ns / 1ps
`default_nettype none

module bapc_back import bapc_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    q_empty,
   input  wire job_type                 q_job,
   output logic                         q_pop,
   output div_ctl_type                  div_ctl,
   input  wire div_sts_type             div_sts,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output logic [RSP_DATA_W-1:0]        rsp_tdata
);

   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_PREP     = 6'b000010,
      ST_DIV_GO   = 6'b000100,
      ST_DIV_WAIT = 6'b001000,
      ST_MUL      = 6'b010000,
      ST_OUT      = 6'b100000
   } state_type;

   typedef enum logic [1:0] {
      SEL_TIME = 2'd0,
      SEL_TEMP = 2'd1,
      SEL_PRES = 2'd2
   } div_sel_type;

   state_type                 state_ff;
   state_type                 state_in;
   div_sel_type               sel_ff;

   job_type                   job_ff;
   logic        [DEN_W-1:0]   den_time_ff;
   logic        [DEN_W-1:0]   den_pres_ff;
   logic        [PNUM_W-1:0]  num_pres_ff;
   logic                      temp_neg_ff;
   logic        [MSUM_W-1:0]  temp_mag_ff;
   logic        [MT_W-1:0]    mt_ff;
   logic        [TEMP_W-1:0]  tmean_ff;
   logic        [V_W-1:0]     v_ff;
   logic signed [PROD_W-1:0]  prod_ff;

   logic                      rsp_valid_ff;
   logic        [RSP_DATA_W-1:0] rsp_data_ff;

   logic signed [V_W:0]       vdiff;
   logic signed [GAIN_W:0]    gain_s;
   logic signed [PROD_W-1:0]  p_adj;
   logic signed [PROD_W-33:0] p_sh;
   logic        [PM_W-1:0]    p_sat;
   logic        [TEMP_W-1:0]  q_temp;
   logic                      out_free;

   assign out_free = ~rsp_valid_ff | rsp_tready;
   assign q_pop    = (state_ff == ST_IDLE) & ~q_empty;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (!q_empty) state_in = ST_PREP;
         ST_PREP:     state_in = ST_DIV_GO;
         ST_DIV_GO:   state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (div_sts.done) state_in = (sel_ff == SEL_PRES) ? ST_MUL : ST_DIV_GO;
         end
         ST_MUL:      state_in = ST_OUT;
         ST_OUT:      if (out_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // divider operands by which quotient is due
   always_comb begin
      div_ctl.start = (state_ff == ST_DIV_GO);
      case (sel_ff)
         SEL_TIME: begin
            div_ctl.dividend = {1'b0, job_ff.time_sum, 8'h00};
            div_ctl.divisor  = den_time_ff;
         end
         SEL_TEMP: begin
            div_ctl.dividend = {{(NUM_W - MSUM_W){1'b0}}, temp_mag_ff};
            div_ctl.divisor  = {{(DEN_W - SCNT_W){1'b0}}, job_ff.n};
         end
         default: begin
            div_ctl.dividend = {num_pres_ff, 16'h0000};
            div_ctl.divisor  = den_pres_ff;
         end
      endcase
   end

   assign q_temp = div_sts.quotient[TEMP_W-1:0];

   // pressure: (v - 1000 mV) * gain / 2^32, truncated toward zero, then clamped
   assign vdiff  = $signed({1'b0, v_ff}) - $signed(OFFSET_Q16);
   assign gain_s = $signed({1'b0, PRES_GAIN_Q16});
   assign p_adj  = prod_ff + (prod_ff[PROD_W-1] ? $signed(PROD_W'(33'h0FFFFFFFF))
                                                : $signed(PROD_W'(0)));
   assign p_sh   = p_adj[PROD_W-1:32];

   always_comb begin
      if (p_sh > $signed((PROD_W-32)'(PRES_MAX))) begin
         p_sat = PM_W'(PRES_MAX);
      end else if (p_sh < $signed((PROD_W-32)'(PRES_MIN))) begin
         p_sat = PM_W'(PRES_MIN);
      end else begin
         p_sat = p_sh[PM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sel_ff   <= SEL_TIME;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_PREP) begin
            sel_ff <= SEL_TIME;
         end else if (state_ff == ST_DIV_WAIT && div_sts.done) begin
            case (sel_ff)
               SEL_TIME: sel_ff <= SEL_TEMP;
               default:  sel_ff <= SEL_PRES;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) job_ff <= q_job;
      if (state_ff == ST_PREP) begin
         den_time_ff <= {{(DEN_W - SCNT_W){1'b0}}, job_ff.n} * DEN_W'(TIME_DIV);
         den_pres_ff <= {{(DEN_W - SCNT_W){1'b0}}, job_ff.n} * DEN_W'(ADC_FULL);
         num_pres_ff <= {{(PNUM_W - REF_W){1'b0}}, job_ff.ref_mv}
                        * {{(PNUM_W - PSUM_W){1'b0}}, job_ff.pres_sum};
         temp_neg_ff <= job_ff.temp_sum[MSUM_W-1];
         temp_mag_ff <= job_ff.temp_sum[MSUM_W-1] ? MSUM_W'(-job_ff.temp_sum)
                                                  : MSUM_W'(job_ff.temp_sum);
      end
      if (state_ff == ST_DIV_WAIT && div_sts.done) begin
         case (sel_ff)
            SEL_TIME: mt_ff    <= div_sts.quotient[MT_W-1:0];
            SEL_TEMP: tmean_ff <= temp_neg_ff ? (~q_temp + 1'b1) : q_temp;
            default:  v_ff     <= div_sts.quotient[V_W-1:0];
         endcase
      end
      if (state_ff == ST_MUL) prod_ff <= vdiff * gain_s;
   end

   // output register, parts the back end from the result consumer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_OUT && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_OUT && out_free) begin
         rsp_data_ff <= {{(RSP_DATA_W - MT_W - TD_W - PM_W){1'b0}},
                         p_sat, tmean_ff, 4'h0, mt_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

// File: hdl/bapc_checker.sv
// port-level checks for the block average converter, bound to the top level
// depends on bapc_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module bapc_checker import bapc_pkg::*; (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata
);

   // a stalled result beat stays put
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata))

   // temperature is whole codes scaled by 16, so its low four bits are clear
   `ASSERT_IMPL(a_temp_scale, clock, reset, rsp_tvalid, rsp_tdata[34:31] == 4'h0)

   // pad above the pressure field
   `ASSERT_IMPL(a_rsp_pad, clock, reset, rsp_tvalid, rsp_tdata[79:74] == 6'h00)

endmodule

bind block_average_pt_converter_unit bapc_checker u_bapc_checker (.*);

`default_nettype wire
